### rtl/pnf_pkg.sv
// Package for the fixed-point 2D Perlin fBm block.
// Holds widths, codes, the sequencer state type, the divider status type and the gradient function.
package pnf_pkg;

   localparam int TABLE_SIZE  = 256;
   localparam int MAX_OCTAVES = 8;
   localparam int FRAC_BITS   = 16;
   localparam int IDX_W       = $clog2(TABLE_SIZE);
   localparam int OCT_W       = $clog2(MAX_OCTAVES + 1);
   localparam int COORD_W     = 32;
   localparam int NOISE_W     = 17;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 17;
   localparam int AMP_W       = FRAC_BITS + 1;
   localparam int ASUM_W      = AMP_W + $clog2(MAX_OCTAVES) + 1;
   localparam int TOTAL_W     = 2 * AMP_W + $clog2(MAX_OCTAVES) + 1;
   localparam int QUOT_W      = FRAC_BITS + 1;
   localparam int MUL_W       = 24;

   localparam logic [CSR_IDX_W-1:0] CSR_OCTAVES     = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PERSISTENCE = 1'd1;
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_EVAL = 1'b1;

   typedef enum logic [4:0] {
      ST_IDLE, ST_F1, ST_F2, ST_F3, ST_F4,
      ST_RD_A, ST_RD_B, ST_RD_AA, ST_RD_AB, ST_RD_BA, ST_RD_BB, ST_RD_END,
      ST_L1, ST_L2, ST_L3, ST_L4, ST_L5, ST_L6, ST_L7,
      ST_DIV_GO, ST_DIV_WAIT, ST_DONE
   } state_type;

   typedef struct packed {
      logic              done;
      logic [QUOT_W-1:0] quotient;
   } div_status_type;

   // Improved Perlin gradient over diagonal directions; codes 1 and 2 both give -dx+dy.
   // The far corner can reach plus two, so the sum carries an extra bit.
   function automatic logic signed [19:0] grad_fx(input logic [1:0] h,
                                                  input logic signed [17:0] dx,
                                                  input logic signed [17:0] dy);
      logic signed [19:0] u;
      logic signed [19:0] v;
      u = h[1] ? 20'(dy) : 20'(dx);
      v = h[1] ? 20'(dx) : 20'(dy);
      if (h[0]) u = -u;
      if (h[1]) v = -v;
      return u + v;
   endfunction

endpackage

### rtl/pnf_if.sv
// Valid/ready channel interfaces for requests and responses.
// Depends on pnf_pkg for the field widths.
interface pnf_req_if import pnf_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               opcode;
   logic [COORD_W-1:0] x_coord;
   logic [COORD_W-1:0] y_coord;
   logic [IDX_W-1:0]   table_index;
   logic [IDX_W-1:0]   table_value;
   modport source (output valid, opcode, x_coord, y_coord, table_index, table_value,
                   input ready);
   modport sink (input valid, opcode, x_coord, y_coord, table_index, table_value,
                 output ready);
endinterface

interface pnf_rsp_if import pnf_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [NOISE_W-1:0] noise_value;
   modport source (output valid, noise_value, input ready);
   modport sink (input valid, noise_value, output ready);
endinterface

### rtl/pnf_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module pnf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     write_enable,
   input  logic [$clog2(DEPTH)-1:0] address,
   input  logic [WIDTH-1:0]         write_data,
   output logic [WIDTH-1:0]         read_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Read first: on a write the read data returns the old contents; read data registered.
   always_ff @(posedge clock) begin
      if (write_enable) mem_ff[address] <= write_data;
      read_data <= mem_ff[address];
   end
endmodule

### rtl/pnf_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on pnf_pkg; the quotient is known to fit in QUOT_W bits.
module pnf_div import pnf_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [TOTAL_W-1:0] dividend,
   input  logic [ASUM_W-1:0]  divisor,
   output div_status_type     status
);
   localparam int CNT_W = $clog2(QUOT_W + 1);

   logic [ASUM_W-1:0]  rem_ff, rem_in;
   logic [QUOT_W-1:0]  quo_ff, quo_in;
   logic [QUOT_W-1:0]  low_ff, low_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [ASUM_W:0]    trial;

   // One shift-and-subtract step per cycle.
   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      low_in  = low_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, low_ff[QUOT_W-1]};
      if (start) begin
         rem_in  = dividend[TOTAL_W-1 -: ASUM_W];
         low_in  = dividend[QUOT_W-1:0];
         quo_in  = '0;
         cnt_in  = CNT_W'(QUOT_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         low_in = {low_ff[QUOT_W-2:0], 1'b0};
         if (trial >= {1'b0, divisor}) begin
            rem_in = ASUM_W'(trial - {1'b0, divisor});
            quo_in = {quo_ff[QUOT_W-2:0], 1'b1};
         end else begin
            rem_in = ASUM_W'(trial);
            quo_in = {quo_ff[QUOT_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      low_ff <= low_in;
   end

   assign status.done     = done_ff;
   assign status.quotient = quo_ff;
endmodule

### rtl/perlin_noise_2d_fbm.sv
// Top level: 2D improved Perlin noise summed over octaves, one shared multiplier.
// A load writes one table entry and stays idle. An evaluate runs, per octave, two fades, six table
// reads and seven lerp and accumulate steps, then the 17-step bit-serial divide and hand-off;
// the next request is taken only once the result is handed off, and a new result waits while
// the previous one is stalled.
// Synchronous reset sets idle, 4 octaves and persistence one half; the table is kept.
module perlin_noise_2d_fbm import pnf_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   pnf_req_if.sink               req_if,
   pnf_rsp_if.source             rsp_if,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);
   localparam logic signed [17:0] ONE18 = 18'sd65536;

   state_type state_ff, state_in;
   logic [3:0]          octaves_ff;
   logic [16:0]         pers_ff;
   logic [OCT_W-1:0]    n_ff, n_in, oct_ff, oct_in;
   logic [16:0]         p_ff, p_in;
   logic [COORD_W-1:0]  cx_ff, cx_in, cy_ff, cy_in;
   logic                fsel_ff, fsel_in;
   logic [19:0]         qh_ff, qh_in;
   logic [16:0]         fu_ff, fu_in, fv_ff, fv_in;
   logic [IDX_W:0]      pa_ff, pa_in, pb_ff, pb_in;
   logic [1:0]          haa_ff, haa_in, hab_ff, hab_in, hba_ff, hba_in, hbb_ff, hbb_in;
   logic signed [19:0]  x1_ff, x1_in, x2_ff, x2_in;
   logic [16:0]         oval_ff, oval_in;
   logic [AMP_W-1:0]    amp_ff, amp_in;
   logic [ASUM_W-1:0]   asum_ff, asum_in;
   logic [TOTAL_W-1:0]  total_ff, total_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [NOISE_W-1:0]  rsp_data_ff, rsp_data_in;
   logic signed [MUL_W-1:0]   mul_a, mul_b;
   logic signed [2*MUL_W-1:0] mul_ff;
   logic signed [2*MUL_W-1:0] mul_sh;
   logic                ram_we;
   logic [IDX_W-1:0]    ram_addr, ram_q;
   logic                div_start;
   div_status_type      div_st;
   logic                accept;
   logic [15:0]         xf, yf, tsel;
   logic [IDX_W-1:0]    xi, yi;
   logic signed [17:0]  dx0, dx1, dy0, dy1;
   logic signed [19:0]  g_aa, g_ab, g_ba, g_bb;
   logic [37:0]         q_full;
   logic signed [21:0]  r_val;
   logic [16:0]         quot_c;

   assign accept        = req_if.valid && req_if.ready;
   assign req_if.ready  = (state_ff == ST_IDLE);
   assign rsp_if.valid  = rsp_valid_ff;
   assign rsp_if.noise_value = rsp_data_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         octaves_ff <= 4'd4;
         pers_ff    <= 17'd32768;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_OCTAVES:     octaves_ff <= csr_write_data[3:0];
            CSR_PERSISTENCE: pers_ff    <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Permutation table.
   pnf_ram #(.WIDTH(IDX_W), .DEPTH(TABLE_SIZE)) u_perm (
      .clock(clock), .write_enable(ram_we), .address(ram_addr),
      .write_data(req_if.table_value), .read_data(ram_q)
   );

   pnf_div u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(total_ff), .divisor(asum_ff), .status(div_st)
   );

   // Shared multiplier with registered product.
   always_ff @(posedge clock) mul_ff <= mul_a * mul_b;
   assign mul_sh = mul_ff >>> FRAC_BITS;

   // Lattice coordinates, offsets and corner gradients.
   assign xi   = cx_ff[FRAC_BITS +: IDX_W];
   assign yi   = cy_ff[FRAC_BITS +: IDX_W];
   assign xf   = cx_ff[FRAC_BITS-1:0];
   assign yf   = cy_ff[FRAC_BITS-1:0];
   assign tsel = fsel_ff ? yf : xf;
   assign dx0  = {2'b00, xf};
   assign dy0  = {2'b00, yf};
   assign dx1  = dx0 - ONE18;
   assign dy1  = dy0 - ONE18;
   assign g_aa = grad_fx(haa_ff, dx0, dy0);
   assign g_ba = grad_fx(hba_ff, dx1, dy0);
   assign g_ab = grad_fx(hab_ff, dx0, dy1);
   assign g_bb = grad_fx(hbb_ff, dx1, dy1);
   assign q_full = 38'd6 * {6'd0, mul_ff[31:0]} + (38'd10 << 32)
                   - ({22'd0, tsel} * 38'd15 << 16);
   assign r_val  = 22'(x1_ff) + 22'(mul_sh) + 22'sd65536;
   assign quot_c = (div_st.quotient > 17'd65536) ? 17'd65536 : div_st.quotient;

   // Sequencer: next state, datapath registers and multiplier operands.
   always_comb begin
      state_in = state_ff;
      n_in = n_ff; oct_in = oct_ff; p_in = p_ff;
      cx_in = cx_ff; cy_in = cy_ff; fsel_in = fsel_ff; qh_in = qh_ff;
      fu_in = fu_ff; fv_in = fv_ff; pa_in = pa_ff; pb_in = pb_ff;
      haa_in = haa_ff; hab_in = hab_ff; hba_in = hba_ff; hbb_in = hbb_ff;
      x1_in = x1_ff; x2_in = x2_ff; oval_in = oval_ff;
      amp_in = amp_ff; asum_in = asum_ff; total_in = total_ff;
      rsp_valid_in = rsp_valid_ff; rsp_data_in = rsp_data_ff;
      mul_a = '0; mul_b = '0;
      ram_we = 1'b0; ram_addr = xi; div_start = 1'b0;
      if (rsp_valid_ff && rsp_if.ready) rsp_valid_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            ram_addr = req_if.table_index;
            if (accept) begin
               if (req_if.opcode == OP_LOAD) begin
                  ram_we = 1'b1;
               end else begin
                  if (octaves_ff == 4'd0) n_in = OCT_W'(1);
                  else if (octaves_ff > 4'(MAX_OCTAVES)) n_in = OCT_W'(MAX_OCTAVES);
                  else n_in = OCT_W'(octaves_ff);
                  p_in     = (pers_ff > 17'd65536) ? 17'd65536 : pers_ff;
                  cx_in    = req_if.x_coord;
                  cy_in    = req_if.y_coord;
                  oct_in   = '0;
                  amp_in   = AMP_W'(65536);
                  asum_in  = '0;
                  total_in = '0;
                  fsel_in  = 1'b0;
                  state_in = ST_F1;
               end
            end
         end
         ST_F1: begin
            mul_a = MUL_W'({1'b0, tsel});
            mul_b = MUL_W'({1'b0, tsel});
            state_in = ST_F2;
         end
         ST_F2: begin
            mul_a = MUL_W'({1'b0, mul_ff[31:16]});
            mul_b = MUL_W'({1'b0, tsel});
            qh_in = q_full[35:16];
            state_in = ST_F3;
         end
         ST_F3: begin
            mul_a = MUL_W'({1'b0, mul_ff[31:16]});
            mul_b = MUL_W'({1'b0, qh_ff});
            state_in = ST_F4;
         end
         ST_F4: begin
            if (fsel_ff) begin
               fv_in = mul_ff[32:16];
               state_in = ST_RD_A;
            end else begin
               fu_in = mul_ff[32:16];
               fsel_in = 1'b1;
               state_in = ST_F1;
            end
         end
         ST_RD_A: begin
            ram_addr = xi;
            state_in = ST_RD_B;
         end
         ST_RD_B: begin
            ram_addr = xi + 1'b1;
            pa_in = {1'b0, ram_q} + {1'b0, yi};
            state_in = ST_RD_AA;
         end
         ST_RD_AA: begin
            ram_addr = pa_ff[IDX_W-1:0];
            pb_in = {1'b0, ram_q} + {1'b0, yi};
            state_in = ST_RD_AB;
         end
         ST_RD_AB: begin
            ram_addr = pa_ff[IDX_W-1:0] + 1'b1;
            haa_in = ram_q[1:0];
            state_in = ST_RD_BA;
         end
         ST_RD_BA: begin
            ram_addr = pb_ff[IDX_W-1:0];
            hab_in = ram_q[1:0];
            state_in = ST_RD_BB;
         end
         ST_RD_BB: begin
            ram_addr = pb_ff[IDX_W-1:0] + 1'b1;
            hba_in = ram_q[1:0];
            state_in = ST_RD_END;
         end
         ST_RD_END: begin
            hbb_in = ram_q[1:0];
            state_in = ST_L1;
         end
         ST_L1: begin
            mul_a = MUL_W'({1'b0, fu_ff});
            mul_b = MUL_W'(20'(g_ba) - 20'(g_aa));
            state_in = ST_L2;
         end
         ST_L2: begin
            x1_in = 20'(g_aa) + 20'(mul_sh);
            mul_a = MUL_W'({1'b0, fu_ff});
            mul_b = MUL_W'(20'(g_bb) - 20'(g_ab));
            state_in = ST_L3;
         end
         ST_L3: begin
            x2_in = 20'(g_ab) + 20'(mul_sh);
            state_in = ST_L4;
         end
         ST_L4: begin
            mul_a = MUL_W'({1'b0, fv_ff});
            mul_b = MUL_W'(x2_ff - x1_ff);
            state_in = ST_L5;
         end
         ST_L5: begin
            // Map to [0,1]: clamp below, halve, clamp above.
            if (r_val < 0) oval_in = '0;
            else if (r_val[21:1] > 21'd65536) oval_in = 17'd65536;
            else oval_in = r_val[17:1];
            state_in = ST_L6;
         end
         ST_L6: begin
            mul_a = MUL_W'({1'b0, oval_ff});
            mul_b = MUL_W'({1'b0, amp_ff});
            state_in = ST_L7;
         end
         ST_L7: begin
            total_in = total_ff + TOTAL_W'(mul_ff[2*AMP_W-1:0]);
            asum_in  = asum_ff + ASUM_W'(amp_ff);
            mul_a = MUL_W'({1'b0, amp_ff});
            mul_b = MUL_W'({1'b0, p_ff});
            state_in = ST_DIV_GO;
            if (oct_ff + 1'b1 != n_ff) state_in = ST_F1;
            oct_in  = oct_ff + 1'b1;
            fsel_in = 1'b0;
         end
         ST_DIV_GO: begin
            div_start = 1'b1;
            state_in = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_st.done) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = quot_c;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      // The amplitude update and coordinate doubling land after the octave's last step.
      if (state_ff == ST_L7) begin
         cx_in = {cx_ff[COORD_W-2:0], 1'b0};
         cy_in = {cy_ff[COORD_W-2:0], 1'b0};
      end
      if (state_ff == ST_F1 && fsel_ff == 1'b0 && oct_ff != '0) begin
         amp_in = mul_ff[FRAC_BITS +: AMP_W];
      end
      if (state_ff == ST_DIV_GO) begin
         amp_in = amp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff <= n_in; oct_ff <= oct_in; p_ff <= p_in;
      cx_ff <= cx_in; cy_ff <= cy_in; fsel_ff <= fsel_in; qh_ff <= qh_in;
      fu_ff <= fu_in; fv_ff <= fv_in; pa_ff <= pa_in; pb_ff <= pb_in;
      haa_ff <= haa_in; hab_ff <= hab_in; hba_ff <= hba_in; hbb_ff <= hbb_in;
      x1_ff <= x1_in; x2_ff <= x2_in; oval_ff <= oval_in;
      amp_ff <= amp_in; asum_ff <= asum_in; total_ff <= total_in;
      rsp_data_ff <= rsp_data_in;
   end
endmodule
